@@ hw/rtl/esc_pkg.sv @@
// ---------------------------------------------------------------------------
// esc_pkg
// shared types and constants of the encoder pid speed controller
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   // register indexes of the configuration port
   localparam logic [3:0] REG_TARGET_SPEED  = 4'd0;
   localparam logic [3:0] REG_PROP_GAIN     = 4'd1;
   localparam logic [3:0] REG_INTEG_GAIN    = 4'd2;
   localparam logic [3:0] REG_DERIV_GAIN    = 4'd3;
   localparam logic [3:0] REG_FEED_OFFSET   = 4'd4;
   localparam logic [3:0] REG_FEED_SLOPE    = 4'd5;
   localparam logic [3:0] REG_RAMP_STEP     = 4'd6;
   localparam logic [3:0] REG_EDGES_PER_REV = 4'd7;

   localparam int DIV_W  = 56;   // dividend and quotient width
   localparam int DVSR_W = 44;   // divisor width
   localparam int U_W    = 58;   // controller sum width, q16 pwm units

   localparam logic [31:0] GAP_MIN_US   = 32'd200;
   localparam logic [31:0] SILENCE_US   = 32'd200000;
   localparam logic [DIV_W-1:0] SPEED_NUM   = DIV_W'(64'd15360000000);
   localparam logic [DIV_W-1:0] INTEG_NUM   = DIV_W'(64'd334233600);
   localparam logic [17:0] SPEED_MAX    = 18'd262143;
   localparam logic [39:0] SUM_MAX      = 40'h7F_FFFF_FFFF;
   localparam logic signed [U_W-1:0] PWM_TOP = U_W'(64'd16711680);

   // divide by five: (x * RECIP5_22) >> 22 exact for x < 2^22,
   // (x * RECIP5_30) >> 30 exact for x < 2^30, and (2^28 - 1) / 5
   localparam logic [19:0] RECIP5_22 = 20'd838861;
   localparam logic [27:0] RECIP5_30 = 28'd214748365;
   localparam logic [25:0] Q28_DIV5  = 26'd53687091;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_EDGE,
      OP_TICK,
      OP_SCAN,
      OP_MEAN_GO,
      OP_MEAN,
      OP_SPD_GO,
      OP_RAW,
      OP_RAW_ZERO,
      OP_RAW_MAX,
      OP_EMA,
      OP_RAMP,
      OP_FF,
      OP_PROP,
      OP_DER1,
      OP_DER2,
      OP_INT1,
      OP_INT2,
      OP_INT_GO,
      OP_INT_ADD,
      OP_LIM_GO,
      OP_LIM,
      OP_FINISH
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHK,
      ST_MEAN_WAIT,
      ST_DEN_CHK,
      ST_SPD_WAIT,
      ST_EMA,
      ST_RAMP,
      ST_FF,
      ST_PROP,
      ST_DER1,
      ST_DER2,
      ST_INT1,
      ST_INT2,
      ST_INT_GO,
      ST_INT_ADD,
      ST_LIM_GO,
      ST_LIM_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic scan_last;
      logic speed_ok;
      logic den_zero;
      logic div_idle;
      logic out_free;
   } status_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/esc_div.sv @@
// ---------------------------------------------------------------------------
// esc_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module esc_div
   import esc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DVSR_W-1:0] divisor,
   output logic                   busy,
   output logic [DIV_W-1:0]       quotient
);

   localparam int CntW = $clog2(DIV_W + 1);

   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   trial;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = DVSR_W'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/esc_ctrl.sv @@
// ---------------------------------------------------------------------------
// esc_ctrl
// sequencer that steps the datapath through one control tick
// ---------------------------------------------------------------------------
`default_nettype none

module esc_ctrl
   import esc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_mode,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  cmd.op   = OP_TICK;
                  state_in = ST_SCAN;
               end else begin
                  cmd.op = OP_EDGE;
               end
            end
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.scan_last) state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.speed_ok) begin
               cmd.op   = OP_MEAN_GO;
               state_in = ST_MEAN_WAIT;
            end else begin
               cmd.op   = OP_RAW_ZERO;
               state_in = ST_EMA;
            end
         end
         ST_MEAN_WAIT: begin
            if (status.div_idle) begin
               cmd.op   = OP_MEAN;
               state_in = ST_DEN_CHK;
            end
         end
         ST_DEN_CHK: begin
            if (status.den_zero) begin
               cmd.op   = OP_RAW_MAX;
               state_in = ST_EMA;
            end else begin
               cmd.op   = OP_SPD_GO;
               state_in = ST_SPD_WAIT;
            end
         end
         ST_SPD_WAIT: begin
            if (status.div_idle) begin
               cmd.op   = OP_RAW;
               state_in = ST_EMA;
            end
         end
         ST_EMA: begin
            cmd.op   = OP_EMA;
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            cmd.op   = OP_RAMP;
            state_in = ST_FF;
         end
         ST_FF: begin
            cmd.op   = OP_FF;
            state_in = ST_PROP;
         end
         ST_PROP: begin
            cmd.op   = OP_PROP;
            state_in = ST_DER1;
         end
         ST_DER1: begin
            cmd.op   = OP_DER1;
            state_in = ST_DER2;
         end
         ST_DER2: begin
            cmd.op   = OP_DER2;
            state_in = ST_INT1;
         end
         ST_INT1: begin
            cmd.op   = OP_INT1;
            state_in = ST_INT2;
         end
         ST_INT2: begin
            cmd.op   = OP_INT2;
            state_in = ST_INT_GO;
         end
         ST_INT_GO: begin
            cmd.op   = OP_INT_GO;
            state_in = ST_INT_ADD;
         end
         ST_INT_ADD: begin
            cmd.op   = OP_INT_ADD;
            state_in = ST_LIM_GO;
         end
         ST_LIM_GO: begin
            cmd.op   = OP_LIM_GO;
            state_in = ST_LIM_WAIT;
         end
         ST_LIM_WAIT: begin
            if (status.div_idle) begin
               cmd.op   = OP_LIM;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/esc_dpath.sv @@
// ---------------------------------------------------------------------------
// esc_dpath
// registers, period ring, multipliers and shared divider of the controller
// ---------------------------------------------------------------------------
`default_nettype none

module esc_dpath
   import esc_pkg::*;
#(
   parameter int PERIOD_TAPS = 12
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        req_time_us,
   input  wire logic               csr_wr_en,
   input  wire logic [3:0]         csr_index,
   input  wire logic [18:0]        csr_wdata,
   input  wire logic               rsp_stall,
   input  wire cmd_type            cmd,
   output status_type              status,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_pwm_duty,
   output logic [17:0]             rsp_filtered_speed,
   output logic [17:0]             rsp_raw_speed,
   output logic signed [18:0]      rsp_ramped_setpoint
);

   localparam int IdxW = (PERIOD_TAPS > 1) ? $clog2(PERIOD_TAPS) : 1;
   localparam int CntW = $clog2(PERIOD_TAPS + 1);
   localparam int AccW = 32 + CntW;

   // configuration
   logic signed [18:0] target_ff;
   logic [15:0] prop_ff, integ_ff, deriv_ff, foff_ff, fslope_ff;
   logic [17:0] ramp_ff;
   logic [11:0] epr_ff;

   // controller state
   logic [31:0] period_ff [PERIOD_TAPS];
   logic [IdxW-1:0] slot_ff;
   logic [31:0] last_ff;
   logic        seen_ff;
   logic [17:0] sf_ff;
   logic signed [18:0] sp_ff;
   logic signed [39:0] esum_ff;
   logic signed [19:0] perr_ff;

   // tick scratch
   logic [31:0] now_ff;
   logic [AccW-1:0] acc_ff;
   logic [CntW-1:0] cnt_ff;
   logic [IdxW-1:0] idx_ff;
   logic [DVSR_W-1:0] den_ff;
   logic [17:0] raw_ff;
   logic signed [19:0] err_ff;
   logic signed [U_W-1:0] u_ff;
   logic signed [37:0] dprod_ff;
   logic [39:0] mag_ff;
   logic        neg_ff;
   logic [DIV_W-1:0] ip_ff;
   logic [51:0] iq_hi_ff;
   logic [28:0] ix_ff;
   logic [39:0] lim_ff;

   // result
   logic        rsp_valid_ff;
   logic [7:0]  pwm_ff;
   logic [17:0] out_sf_ff, out_raw_ff;
   logic signed [18:0] out_sp_ff;

   // divider
   logic              div_start;
   logic [DIV_W-1:0]  div_dvd;
   logic [DVSR_W-1:0] div_dvsr;
   logic              div_busy;
   logic [DIV_W-1:0]  div_quo;

   esc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvsr),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // combinational helpers
   logic [31:0] gap, since;
   logic [11:0] epr1;
   logic signed [20:0] sp_ext, tgt_ext, ramp_up, ramp_dn;
   logic signed [35:0] ff_mul;
   logic signed [36:0] p_mul;
   logic signed [20:0] derr;
   logic signed [U_W-1:0] ff_term, d_term;
   logic [35:0] ip_lo, ip_hi;
   logic signed [40:0] new_sum, lim_pos, lim_neg;
   logic [20:0] ema_num;
   logic [40:0] ema_prod;
   logic [56:0] iq_lo_prod;
   logic [52:0] iq;

   always_comb begin
      gap     = req_time_us - last_ff;
      since   = now_ff - last_ff;
      epr1    = (epr_ff == 12'd0) ? 12'd1 : epr_ff;
      sp_ext  = 21'(sp_ff);
      tgt_ext = 21'(target_ff);
      ramp_up = sp_ext + $signed({3'b000, ramp_ff});
      ramp_dn = sp_ext - $signed({3'b000, ramp_ff});
      ff_mul  = $signed({1'b0, fslope_ff}) * sp_ff;
      ff_term = U_W'($signed({1'b0, foff_ff, 8'h00})) + U_W'(ff_mul);
      p_mul   = $signed({1'b0, prop_ff}) * err_ff;
      derr    = 21'(err_ff) - 21'(perr_ff);
      d_term  = (U_W'(dprod_ff) <<< 4) + (U_W'(dprod_ff) <<< 2);
      ip_lo   = integ_ff * mag_ff[19:0];
      ip_hi   = integ_ff * mag_ff[39:20];
      new_sum = 41'(esum_ff) + 41'(err_ff);
      lim_pos = $signed({1'b0, lim_ff});
      lim_neg = -lim_pos;
      ema_num = {1'b0, sf_ff, 2'b00} + {3'b000, raw_ff} + 21'd2;
      // divide by five through a reciprocal multiply
      ema_prod   = 41'(ema_num) * 41'(RECIP5_22);
      // gain times integral magnitude / 20: high part times (2^28-1)/5 plus the folded low part / 5
      iq_lo_prod = 57'(ix_ff) * 57'(RECIP5_30);
      iq         = 53'(iq_hi_ff) + 53'(iq_lo_prod[56:30]);

      div_start = 1'b0;
      div_dvd   = '0;
      div_dvsr  = '0;
      case (cmd.op)
         OP_MEAN_GO: begin
            div_start = 1'b1;
            div_dvd   = DIV_W'(acc_ff);
            div_dvsr  = DVSR_W'(cnt_ff);
         end
         OP_SPD_GO: begin
            div_start = 1'b1;
            div_dvd   = SPEED_NUM;
            div_dvsr  = den_ff;
         end
         OP_LIM_GO: begin
            div_start = 1'b1;
            div_dvd   = INTEG_NUM;
            div_dvsr  = DVSR_W'(integ_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 19'sd11520;
         prop_ff   <= 16'd128;
         integ_ff  <= 16'd154;
         deriv_ff  <= 16'd0;
         foff_ff   <= 16'd7680;
         fslope_ff <= 16'd269;
         ramp_ff   <= 18'd1152;
         epr_ff    <= 12'd752;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_SPEED:  target_ff <= $signed(csr_wdata);
            REG_PROP_GAIN:     prop_ff   <= csr_wdata[15:0];
            REG_INTEG_GAIN:    integ_ff  <= csr_wdata[15:0];
            REG_DERIV_GAIN:    deriv_ff  <= csr_wdata[15:0];
            REG_FEED_OFFSET:   foff_ff   <= csr_wdata[15:0];
            REG_FEED_SLOPE:    fslope_ff <= csr_wdata[15:0];
            REG_RAMP_STEP:     ramp_ff   <= csr_wdata[17:0];
            REG_EDGES_PER_REV: epr_ff    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PERIOD_TAPS; i++) period_ff[i] <= '0;
         slot_ff      <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         sf_ff        <= '0;
         sp_ff        <= '0;
         esum_ff      <= '0;
         perr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_EDGE: begin
               last_ff <= req_time_us;
               if (gap > GAP_MIN_US) begin
                  period_ff[slot_ff] <= gap;
                  slot_ff <= (slot_ff == IdxW'(PERIOD_TAPS - 1)) ? '0 : slot_ff + 1'b1;
                  seen_ff <= 1'b1;
               end
            end
            OP_EMA: sf_ff <= ema_prod[39:22];
            OP_RAMP: begin
               if (sp_ext < tgt_ext) begin
                  sp_ff <= (ramp_up < tgt_ext) ? ramp_up[18:0] : target_ff;
               end else if (sp_ext > tgt_ext) begin
                  sp_ff <= (ramp_dn > tgt_ext) ? ramp_dn[18:0] : target_ff;
               end
            end
            OP_FINISH: begin
               if (u_ff > 0 && u_ff < PWM_TOP) begin
                  if (new_sum > lim_pos) esum_ff <= lim_pos[39:0];
                  else if (new_sum < lim_neg) esum_ff <= lim_neg[39:0];
                  else esum_ff <= new_sum[39:0];
               end
               perr_ff      <= err_ff;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // scratch and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TICK: begin
            now_ff <= req_time_us;
            acc_ff <= '0;
            cnt_ff <= '0;
            idx_ff <= '0;
         end
         OP_SCAN: begin
            if (period_ff[idx_ff] != 32'd0) begin
               acc_ff <= acc_ff + AccW'(period_ff[idx_ff]);
               cnt_ff <= cnt_ff + 1'b1;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         OP_MEAN:     den_ff <= DVSR_W'(div_quo[31:0]) * DVSR_W'(epr1);
         OP_RAW:      raw_ff <= (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[17:0];
         OP_RAW_ZERO: raw_ff <= '0;
         OP_RAW_MAX:  raw_ff <= SPEED_MAX;
         OP_FF: begin
            err_ff <= 20'(sp_ext) - $signed({2'b00, sf_ff});
            u_ff   <= (sp_ff > 0) ? ff_term : '0;
         end
         OP_PROP: u_ff <= u_ff + U_W'(p_mul);
         OP_DER1: dprod_ff <= $signed({1'b0, deriv_ff}) * derr;
         OP_DER2: u_ff <= u_ff + d_term;
         OP_INT1: begin
            neg_ff <= esum_ff[39];
            mag_ff <= esum_ff[39] ? 40'(-esum_ff) : esum_ff;
         end
         OP_INT2:    ip_ff <= DIV_W'(ip_lo) + (DIV_W'(ip_hi) << 20);
         // product / 4 split at bit 28, since 2^28 is one more than a multiple of 5
         OP_INT_GO: begin
            iq_hi_ff <= 52'(ip_ff[55:30]) * 52'(Q28_DIV5);
            ix_ff    <= 29'(ip_ff[55:30]) + 29'(ip_ff[29:2]);
         end
         // magnitude quotient, sign put back so the term truncates toward zero
         OP_INT_ADD: u_ff <= neg_ff ? u_ff - $signed(U_W'(iq)) : u_ff + $signed(U_W'(iq));
         OP_LIM:     lim_ff <= (integ_ff == 16'd0) ? SUM_MAX : div_quo[39:0];
         OP_FINISH: begin
            if (u_ff < 0) pwm_ff <= 8'd0;
            else if (u_ff >= PWM_TOP) pwm_ff <= 8'd255;
            else pwm_ff <= u_ff[23:16];
            out_sf_ff  <= sf_ff;
            out_raw_ff <= raw_ff;
            out_sp_ff  <= sp_ff;
         end
         default: ;
      endcase
   end

   assign status.scan_last = (idx_ff == IdxW'(PERIOD_TAPS - 1));
   assign status.speed_ok  = seen_ff && (since <= SILENCE_US) && (cnt_ff != '0);
   assign status.den_zero  = (den_ff == '0);
   assign status.div_idle  = !div_busy;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pwm_duty        = pwm_ff;
   assign rsp_filtered_speed  = out_sf_ff;
   assign rsp_raw_speed       = out_raw_ff;
   assign rsp_ramped_setpoint = out_sp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/encoder_pid_speed_controller_unit.sv @@
// ---------------------------------------------------------------------------
// encoder_pid_speed_controller_unit
// encoder speed measurement with ema filter, ramped setpoint, feedforward+pid
// ---------------------------------------------------------------------------
// edge beat: taken without a stall, and the next beat may follow in the next cycle
// tick beat: result set by the ring scan and up to three passes through the
//   shared divider (mean period, speed, integrator limit); only the limit pass
//   runs when the speed is forced to zero
// the sequencer goes idle at the edge that registers the result; a stalled
//   result holds the sequencer until it leaves
// synchronous active-high reset clears the ring, speeds, integrator and
//   restores register defaults; no clearing pass
`default_nettype none

module encoder_pid_speed_controller_unit
   import esc_pkg::*;
#(
   parameter int PERIOD_TAPS = 12
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [31:0]        req_time_us,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_pwm_duty,
   output logic [17:0]             rsp_filtered_speed,
   output logic [17:0]             rsp_raw_speed,
   output logic signed [18:0]      rsp_ramped_setpoint,
   // register writes
   input  wire logic               csr_wr_en,
   input  wire logic [3:0]         csr_index,
   input  wire logic [18:0]        csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one op per cycle, waits on the divider and the output register
   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: period ring, filter, ramp, pid terms, result beat
   esc_dpath #(
      .PERIOD_TAPS (PERIOD_TAPS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_time_us         (req_time_us),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_stall           (rsp_stall),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_pwm_duty        (rsp_pwm_duty),
      .rsp_filtered_speed  (rsp_filtered_speed),
      .rsp_raw_speed       (rsp_raw_speed),
      .rsp_ramped_setpoint (rsp_ramped_setpoint)
   );

endmodule

`default_nettype wire

@@ hw/rtl/esc_checker.sv @@
// ---------------------------------------------------------------------------
// esc_checker
// port-level checks of the speed controller
// ---------------------------------------------------------------------------
`default_nettype none

module esc_checker
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_mode,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_pwm_duty
);

   // edge beats never make a result
   a_edge_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_mode |=> !$rose(rsp_valid))
      else $error("edge beat produced a result");

   // a tick keeps the input stalled while it is worked
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode |=> req_stall)
      else $error("input not stalled after tick");

   // a new result never appears while the input is open
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a tick in progress");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pwm_duty))
      else $error("stalled result changed");

endmodule

bind encoder_pid_speed_controller_unit esc_checker u_esc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_pwm_duty (rsp_pwm_duty)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the encoder pid speed controller: encoder edges and
// control ticks go in through a gapped valid/stall driver, a bit-exact model
// predicts each tick's result and a monitor compares it under random stall
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
   import esc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS = 12;

   // one input beat: mode 0 is an encoder edge, mode 1 a control tick
   typedef struct {
      logic        mode;
      logic [31:0] stamp;
   } beat_type;

   // one control result
   typedef struct {
      logic [7:0]  duty;
      logic [17:0] filt;
      logic [17:0] raw;
      logic [18:0] setp;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_time_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pwm_duty;
   logic [17:0] rsp_filtered_speed;
   logic [17:0] rsp_raw_speed;
   logic signed [18:0] rsp_ramped_setpoint;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [18:0] csr_wdata = '0;

   encoder_pid_speed_controller_unit #(.PERIOD_TAPS(TAPS)) i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_time_us,
      .rsp_valid, .rsp_stall, .rsp_pwm_duty, .rsp_filtered_speed,
      .rsp_raw_speed, .rsp_ramped_setpoint,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // controller model: registers and state
   // ------------------------------------------------------------------
   logic [18:0] m_target;
   logic [15:0] m_kp, m_ki, m_kd, m_ff_off, m_ff_slope;
   logic [17:0] m_ramp;
   logic [11:0] m_epr;

   logic [31:0] ring [TAPS];
   int          ring_slot;
   logic [31:0] last_edge;
   bit          pulse_seen;
   longint      filt_speed;
   longint      setp_ramped;
   longint      err_sum;
   longint      prev_err;

   beat_type   pending_beats[$];
   result_type expected_results[$];
   int        fail_count = 0;
   bit        req_taken = 0;
   bit        quiet = 0;        // no idling on either side while set
   int        feed_gap = 0;
   int        stall_left = 0;
   logic [31:0] now_us = '0;

   function automatic void model_reset();
      m_target = 19'd11520; m_kp = 16'd128; m_ki = 16'd154; m_kd = 16'd0;
      m_ff_off = 16'd7680; m_ff_slope = 16'd269; m_ramp = 18'd1152; m_epr = 12'd752;
      foreach (ring[i]) ring[i] = '0;
      ring_slot = 0; last_edge = '0; pulse_seen = 0;
      filt_speed = 0; setp_ramped = 0; err_sum = 0; prev_err = 0;
   endfunction

   function automatic void model_write(logic [3:0] idx, logic [18:0] val);
      case (idx)
         REG_TARGET_SPEED:  m_target = val;
         REG_PROP_GAIN:     m_kp = val[15:0];
         REG_INTEG_GAIN:    m_ki = val[15:0];
         REG_DERIV_GAIN:    m_kd = val[15:0];
         REG_FEED_OFFSET:   m_ff_off = val[15:0];
         REG_FEED_SLOPE:    m_ff_slope = val[15:0];
         REG_RAMP_STEP:     m_ramp = val[17:0];
         REG_EDGES_PER_REV: m_epr = val[11:0];
         default: ;
      endcase
   endfunction

   // speed from the mean of the nonzero ring entries
   function automatic longint speed_from_ring(logic [31:0] stamp);
      longint unsigned total, cnt, mean, den, q;
      logic [31:0] since;
      total = 0; cnt = 0;
      since = stamp - last_edge;
      if (!pulse_seen || since > 32'd200000) return 0;
      foreach (ring[i])
         if (ring[i] != 0) begin
            total += ring[i];
            cnt++;
         end
      if (cnt == 0) return 0;
      mean = total / cnt;
      if (mean == 0) return 262143;
      den = mean * ((m_epr == 0) ? 64'd1 : longint'(m_epr));
      q = 64'd15360000000 / den;
      return (q > 262143) ? 262143 : longint'(q);
   endfunction

   // apply one beat, returns 1 and a result for a control tick
   function automatic bit model_beat(beat_type b, output result_type r);
      logic [31:0] gap;
      longint raw, tgt, nxt, err, u, lim;
      r = '{default: '0};
      if (b.mode == 1'b0) begin
         gap = b.stamp - last_edge;
         last_edge = b.stamp;
         if (gap > 32'd200) begin
            ring[ring_slot] = gap;
            ring_slot = (ring_slot + 1) % TAPS;
            pulse_seen = 1;
         end
         return 0;
      end
      raw = speed_from_ring(b.stamp);
      filt_speed = (filt_speed * 4 + raw + 2) / 5;
      tgt = longint'(signed'(m_target));
      // ramp toward the target without overshoot
      if (setp_ramped < tgt) begin
         nxt = setp_ramped + longint'(m_ramp);
         setp_ramped = (nxt < tgt) ? nxt : tgt;
      end else if (setp_ramped > tgt) begin
         nxt = setp_ramped - longint'(m_ramp);
         setp_ramped = (nxt > tgt) ? nxt : tgt;
      end
      err = setp_ramped - filt_speed;
      u = 0;
      if (setp_ramped > 0)
         u = longint'(m_ff_off) * 256 + longint'(m_ff_slope) * setp_ramped;
      u += longint'(m_kp) * err;
      u += (longint'(m_ki) * err_sum) / 20;     // truncates toward zero
      u += longint'(m_kd) * (err - prev_err) * 20;
      // anti-windup: integrate only while the drive is unsaturated
      if (u > 0 && u < 64'sd16711680) begin
         err_sum += err;
         lim = (m_ki != 0) ? 64'sd334233600 / longint'(m_ki) : 64'sd549755813887;
         if (lim > 64'sd549755813887) lim = 64'sd549755813887;
         if (err_sum > lim) err_sum = lim;
         if (err_sum < -lim) err_sum = -lim;
      end
      prev_err = err;
      if (u < 0) u = 0;
      if (u > 64'sd16711680) u = 64'sd16711680;
      r.duty = u[23:16];
      r.filt = filt_speed[17:0];
      r.raw  = raw[17:0];
      r.setp = setp_ramped[18:0];
      return 1;
   endfunction

   // ------------------------------------------------------------------
   // request driver: new beat or gap at the falling edge
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 75) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(20, 120);
   endfunction

   always @(negedge clock) begin
      beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (feed_gap > 0) begin
            feed_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_mode <= b.mode;
            req_time_us <= b.stamp;
            req_valid <= 1'b1;
            feed_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stall
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // ------------------------------------------------------------------
   // monitor: check results, then predict from accepted request beats
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want, got;
      beat_type b;
      req_taken = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pwm_duty, rsp_filtered_speed, rsp_raw_speed, rsp_ramped_setpoint};
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.duty !== want.duty) begin
                  $error("pwm_duty expected %0d got %0d", want.duty, got.duty);
                  fail_count++;
               end
               if (got.filt !== want.filt) begin
                  $error("filtered_speed expected %0d got %0d", want.filt, got.filt);
                  fail_count++;
               end
               if (got.raw !== want.raw) begin
                  $error("raw_speed expected %0d got %0d", want.raw, got.raw);
                  fail_count++;
               end
               if (got.setp !== want.setp) begin
                  $error("ramped_setpoint expected %0d got %0d",
                         signed'(want.setp), signed'(got.setp));
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1;
            b.mode = req_mode;
            b.stamp = req_time_us;
            if (model_beat(b, want)) expected_results.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic reg_write(logic [3:0] idx, logic [18:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      model_write(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic void push_beat(logic mode, logic [31:0] stamp);
      beat_type b;
      b.mode = mode;
      b.stamp = stamp;
      pending_beats.push_back(b);
   endfunction

   // let everything drain, then allow a tick's worth of cycles
   task automatic drain();
      wait (pending_beats.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'hFFFF;
      if (r == 1) return 16'd0;
      if (r < 4) return 16'($urandom);
      return 16'($urandom_range(0, 1024));
   endfunction

   // motor runs with random content, plus noise and silence
   task automatic random_traffic(int count);
      int period, r;
      period = $urandom_range(201, 4000);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 62) begin
            now_us += period + $urandom_range(0, period / 8);
            push_beat(1'b0, now_us);
         end else if (r < 88) begin
            now_us += $urandom_range(0, 3000);
            push_beat(1'b1, now_us);
         end else if (r < 92) begin
            // bounce: short gaps that stay out of the ring
            now_us += $urandom_range(0, 200);
            push_beat(1'b0, now_us);
         end else if (r < 95) begin
            now_us += $urandom_range(150000, 400000);
            push_beat(1'b1, now_us);
         end else if (r < 98) begin
            period = $urandom_range(201, 20000);
         end else begin
            now_us = $urandom;
            push_beat(1'($urandom), now_us);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: no pulse, gap thresholds, silence, time wrap
      quiet = 1;
      push_beat(1'b1, 32'd0);
      push_beat(1'b0, 32'd100);
      push_beat(1'b0, 32'd300);
      push_beat(1'b0, 32'd501);
      push_beat(1'b1, 32'd600);
      push_beat(1'b0, 32'd1501);
      push_beat(1'b0, 32'd2501);
      push_beat(1'b1, 32'd3000);
      push_beat(1'b1, 32'd202501);
      push_beat(1'b1, 32'd202502);
      push_beat(1'b0, 32'hFFFF_FF00);
      push_beat(1'b0, 32'h0000_0200);
      push_beat(1'b1, 32'h0000_0300);
      push_beat(1'b0, 32'hFFFF_FFFF);
      push_beat(1'b1, 32'hFFFF_FFFF);
      push_beat(1'b0, 32'h0000_0000);
      push_beat(1'b1, 32'h0000_0010);
      drain();

      // top extremes, also a write to an unused index
      reg_write(REG_TARGET_SPEED, 19'h3FFFF);
      reg_write(REG_PROP_GAIN, 19'hFFFF);
      reg_write(REG_INTEG_GAIN, 19'hFFFF);
      reg_write(REG_DERIV_GAIN, 19'hFFFF);
      reg_write(REG_FEED_OFFSET, 19'hFFFF);
      reg_write(REG_FEED_SLOPE, 19'hFFFF);
      reg_write(REG_RAMP_STEP, 19'h3FFFF);
      reg_write(REG_EDGES_PER_REV, 19'hFFF);
      reg_write(4'd15, 19'h7FFFF);
      push_beat(1'b0, 32'd1000);
      push_beat(1'b0, 32'd1201);
      push_beat(1'b1, 32'd1300);
      push_beat(1'b1, 32'd1400);
      drain();

      // bottom extremes: zero gains, zero edge count, most negative target
      reg_write(REG_TARGET_SPEED, 19'h40000);
      reg_write(REG_PROP_GAIN, 19'd0);
      reg_write(REG_INTEG_GAIN, 19'd0);
      reg_write(REG_DERIV_GAIN, 19'd0);
      reg_write(REG_FEED_OFFSET, 19'd0);
      reg_write(REG_FEED_SLOPE, 19'd0);
      reg_write(REG_RAMP_STEP, 19'd0);
      reg_write(REG_EDGES_PER_REV, 19'd0);
      now_us = 32'd5000;
      quiet = 0;
      random_traffic(60);
      drain();

      // random settings, mostly in a useful control range
      for (int ph = 0; ph < 8; ph++) begin
         quiet = (ph % 3 == 2);
         reg_write(REG_TARGET_SPEED, ($urandom_range(0, 3) == 0) ?
                   19'($urandom) : 19'($urandom_range(0, 60000)));
         reg_write(REG_PROP_GAIN, 19'(rand_gain()));
         reg_write(REG_INTEG_GAIN, ($urandom_range(0, 4) == 0) ? 19'd0 : 19'(rand_gain()));
         reg_write(REG_DERIV_GAIN, 19'(rand_gain()));
         reg_write(REG_FEED_OFFSET, 19'($urandom_range(0, 65535)));
         reg_write(REG_FEED_SLOPE, 19'(rand_gain()));
         reg_write(REG_RAMP_STEP, ($urandom_range(0, 3) == 0) ?
                   19'($urandom_range(0, 262143)) : 19'($urandom_range(0, 4000)));
         reg_write(REG_EDGES_PER_REV, ($urandom_range(0, 5) == 0) ?
                   19'($urandom_range(0, 4095)) : 19'($urandom_range(1, 1000)));
         random_traffic(70);
         drain();
      end

      if (expected_results.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("** encoder_pid_speed_controller_unit: PASSED **");
      end else begin
         $display("** encoder_pid_speed_controller_unit: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("** encoder_pid_speed_controller_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
